[hw/rtl/mlp_pkg.sv]
// Shared constants, types and command codes for the two-layer ReLU MLP.
`default_nettype none
package mlp_pkg;
    localparam int DIM     = 32;
    localparam int IDX_W   = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int WADDR_W = $clog2(DIM * DIM);
    localparam int ACC_W   = 32 + IDX_W + 2;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [WADDR_W-1:0] t_waddr;
    typedef logic [QPTR_W-1:0]  t_qptr;
    typedef logic [QPTR_W:0]    t_qcnt;

    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_BIAS   = 2'd1;
    localparam logic [1:0] CMD_ELEM   = 2'd2;

    typedef enum logic [2:0] {
        OP_W1,
        OP_W2,
        OP_B1,
        OP_B2,
        OP_ELEM,
        OP_RUN
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [15:0] value;
    } t_cmd;

    typedef struct packed {
        logic [4:0]         idx;
        logic signed [15:0] value;
        logic               last;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_FIN
    } t_state;
endpackage
`default_nettype wire

[hw/rtl/two_layer_relu_mlp.sv]
// Top level of the two-layer ReLU MLP: front end, command queue and compute engine.
//
//  channel   handshake          payload
//  input     i_push / o_full    i_cmd, i_layer, i_row, i_col, i_value
//  result    o_empty / i_pop    o_out_index, o_out_value, o_last
//
// Writes and non-final elements are stored by the engine after a short
// trip through the four-entry command queue. The final element is dequeued,
// then each layer runs on the single shared MAC: for each output the engine
// issues the products, drains the MAC pipeline and then finishes the output.
// A full result queue holds the second layer; input transfers continue until
// the command queue fills. Synchronous active-low reset clears control only.
`default_nettype none
module two_layer_relu_mlp (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [1:0]  i_cmd,
    input  wire logic        i_layer,
    input  wire logic [4:0]  i_row,
    input  wire logic [4:0]  i_col,
    input  wire logic [15:0] i_value,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [4:0]       o_out_index,
    output logic [15:0]      o_out_value,
    output logic             o_last
);
    import mlp_pkg::*;

    t_cmd front_item, q_item;
    logic q_push, q_pop, q_valid, q_full;

    assign o_full = q_full;

    mlp_front u_front (
        .i_push   (i_push),
        .i_cmd    (i_cmd),
        .i_layer  (i_layer),
        .i_row    (i_row),
        .i_col    (i_col),
        .i_value  (i_value),
        .i_q_full (q_full),
        .o_item   (front_item),
        .o_q_push (q_push)
    );

    mlp_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    mlp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out_index (o_out_index),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );
endmodule
`default_nettype wire

[hw/rtl/mlp_front.sv]
// Front end: accept items, drop unusable ones and classify the rest into queue commands.
`default_nettype none
module mlp_front (
    input  wire logic           i_push,
    input  wire logic [1:0]     i_cmd,
    input  wire logic           i_layer,
    input  wire logic [4:0]     i_row,
    input  wire logic [4:0]     i_col,
    input  wire logic [15:0]    i_value,
    input  wire logic           i_q_full,
    output mlp_pkg::t_cmd       o_item,
    output logic                o_q_push
);
    import mlp_pkg::*;

    logic keep;
    t_op  op;

    always_comb begin
        keep = 1'b0;
        op   = OP_ELEM;
        case (i_cmd)
            CMD_WEIGHT: begin
                keep = (int'(i_row) < DIM) && (int'(i_col) < DIM);
                op   = i_layer ? OP_W2 : OP_W1;
            end
            CMD_BIAS: begin
                keep = int'(i_col) < DIM;
                op   = i_layer ? OP_B2 : OP_B1;
            end
            CMD_ELEM: begin
                keep = int'(i_row) < DIM;
                op   = (int'(i_row) == DIM - 1) ? OP_RUN : OP_ELEM;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_item.op    = op;
    assign o_item.row   = i_row;
    assign o_item.col   = i_col;
    assign o_item.value = i_value;
    // drop filtered items: they complete their transfer but never enter the queue
    assign o_q_push     = i_push && !i_q_full && keep;
endmodule
`default_nettype wire

[hw/rtl/mlp_cmd_fifo.sv]
// Short command queue between the front end and the compute engine.
`default_nettype none
module mlp_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mlp_pkg::t_cmd i_item,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output mlp_pkg::t_cmd      o_item
);
    import mlp_pkg::*;

    t_cmd  r_mem [QDEPTH];
    t_qptr r_wp, r_rp;
    t_qcnt r_cnt;
    logic  do_push, do_pop;

    assign o_full  = (int'(r_cnt) == QDEPTH);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

[hw/rtl/mlp_back.sv]
// Back end: weight, bias and vector stores, shared MAC sequencer and result queue.
`default_nettype none
module mlp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire mlp_pkg::t_cmd i_q_item,
    output logic               o_q_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [4:0]         o_out_index,
    output logic [15:0]        o_out_value,
    output logic               o_last
);
    import mlp_pkg::*;

    logic signed [15:0] r_w1 [DIM*DIM];
    logic signed [15:0] r_w2 [DIM*DIM];
    logic signed [15:0] r_b1 [DIM];
    logic signed [15:0] r_b2 [DIM];
    logic signed [15:0] r_xv [DIM];
    logic signed [15:0] r_hv [DIM];

    t_state r_state, n_state;
    t_idx   r_i, r_j;
    logic   r_layer2;
    logic   r_v1, r_v2;
    logic   r_sel2;
    logic signed [15:0]      r_w1_q, r_w2_q, r_x_q, r_h_q, r_b1_q, r_b2_q;
    logic signed [31:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic   issue, fin_fire, pop_cmd;
    logic   ob_full;
    t_waddr wr_addr, rd_addr;
    t_idx   cmd_row, cmd_col;

    logic signed [ACC_W-1:0] bias_ext, sum, shifted;
    logic signed [15:0]      sat_val, hid_val;

    t_res   r_ob [2];
    logic   r_ob_wp, r_ob_rp;
    logic [1:0] r_ob_cnt;
    logic   ob_push, ob_pop;

    assign cmd_row = t_idx'(i_q_item.row);
    assign cmd_col = t_idx'(i_q_item.col);
    assign wr_addr = t_waddr'(int'(cmd_row) * DIM + int'(cmd_col));
    assign rd_addr = t_waddr'(int'(r_i) * DIM + int'(r_j));
    assign ob_full = (r_ob_cnt == 2'd2);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && i_q_item.op == OP_RUN) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (r_i == t_idx'(DIM - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!(r_layer2 && ob_full)) begin
                    n_state = (r_layer2 && r_j == t_idx'(DIM - 1)) ? S_IDLE : S_ISSUE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        issue    = 1'b0;
        fin_fire = 1'b0;
        pop_cmd  = 1'b0;
        case (r_state)
            S_IDLE:  pop_cmd  = i_q_valid;
            S_ISSUE: issue    = 1'b1;
            S_FIN:   fin_fire = !(r_layer2 && ob_full);
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    assign o_q_pop = pop_cmd;

    // stores: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (pop_cmd && i_q_item.op == OP_W1) begin
            r_w1[wr_addr] <= i_q_item.value;
        end
        r_w1_q <= r_w1[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pop_cmd && i_q_item.op == OP_W2) begin
            r_w2[wr_addr] <= i_q_item.value;
        end
        r_w2_q <= r_w2[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pop_cmd && i_q_item.op == OP_B1) begin
            r_b1[cmd_col] <= i_q_item.value;
        end
        r_b1_q <= r_b1[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (pop_cmd && i_q_item.op == OP_B2) begin
            r_b2[cmd_col] <= i_q_item.value;
        end
        r_b2_q <= r_b2[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (pop_cmd && (i_q_item.op == OP_ELEM || i_q_item.op == OP_RUN)) begin
            r_xv[cmd_row] <= i_q_item.value;
        end
        r_x_q <= r_xv[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (fin_fire && !r_layer2) begin
            r_hv[r_j] <= hid_val;
        end
        r_h_q <= r_hv[r_i];
    end

    // multiply and accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= r_sel2 ? (r_w2_q * r_h_q) : (r_w1_q * r_x_q);
        if (issue && r_i == '0) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // round half up, saturate; relu only for hidden-layer values
    always_comb begin
        bias_ext = ACC_W'(r_layer2 ? r_b2_q : r_b1_q);
        sum      = r_acc + (bias_ext <<< 8) + ACC_W'(128);
        shifted  = sum >>> 8;
        if (shifted > ACC_W'(32767)) begin
            sat_val = 16'sd32767;
        end else if (shifted < -ACC_W'(32768)) begin
            sat_val = -16'sd32768;
        end else begin
            sat_val = shifted[15:0];
        end
        hid_val = sat_val[15] ? 16'sd0 : sat_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_i      <= '0;
            r_j      <= '0;
            r_layer2 <= 1'b0;
            r_sel2   <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_sel2  <= r_layer2;
            if (pop_cmd && i_q_item.op == OP_RUN) begin
                r_i      <= '0;
                r_j      <= '0;
                r_layer2 <= 1'b0;
            end
            if (issue) begin
                r_i <= (r_i == t_idx'(DIM - 1)) ? '0 : r_i + 1'b1;
            end
            if (fin_fire) begin
                if (r_j == t_idx'(DIM - 1)) begin
                    r_j      <= '0;
                    r_layer2 <= 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
        end
    end

    // result queue
    assign ob_push     = fin_fire && r_layer2;
    assign o_empty     = (r_ob_cnt == 2'd0);
    assign ob_pop      = i_pop && !o_empty;
    assign o_out_index = r_ob[r_ob_rp].idx;
    assign o_out_value = r_ob[r_ob_rp].value;
    assign o_last      = r_ob[r_ob_rp].last;

    always_ff @(posedge i_clk) begin
        if (ob_push) begin
            r_ob[r_ob_wp].idx   <= 5'(r_j);
            r_ob[r_ob_wp].value <= sat_val;
            r_ob[r_ob_wp].last  <= (r_j == t_idx'(DIM - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
            r_ob_cnt <= 2'd0;
        end else begin
            if (ob_push) begin
                r_ob_wp <= ~r_ob_wp;
            end
            if (ob_pop) begin
                r_ob_rp <= ~r_ob_rp;
            end
            case ({ob_push, ob_pop})
                2'b10:   r_ob_cnt <= r_ob_cnt + 2'd1;
                2'b01:   r_ob_cnt <= r_ob_cnt - 2'd1;
                default: r_ob_cnt <= r_ob_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the two-layer ReLU MLP with a scoreboard class.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import mlp_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RUN_CYCLES = 2 * DIM * (DIM + 4) + 64;

    typedef struct {
        logic [4:0]         idx;
        logic signed [15:0] value;
        logic               last;
    } t_out_elem;

    class mlp_scoreboard;
        logic signed [15:0] w1 [DIM*DIM];
        logic signed [15:0] w2 [DIM*DIM];
        logic signed [15:0] b1 [DIM];
        logic signed [15:0] b2 [DIM];
        logic signed [15:0] xvec [DIM];
        logic signed [15:0] hvec [DIM];
        t_out_elem          expected_outputs [$];
        int                 mismatches;

        function new();
            mismatches = 0;
            foreach (w1[k]) begin
                w1[k] = '0;
                w2[k] = '0;
            end
            foreach (b1[k]) begin
                b1[k] = '0;
                b2[k] = '0;
                xvec[k] = '0;
                hvec[k] = '0;
            end
        endfunction

        function logic signed [15:0] round_sat(longint acc);
            longint r;
            r = (acc + 128) >>> 8;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[15:0];
        endfunction

        function logic signed [15:0] dot_column(bit second, int j);
            longint acc;
            acc = (second ? longint'(b2[j]) : longint'(b1[j])) * 256;
            for (int i = 0; i < DIM; i++) begin
                if (second) acc += longint'(w2[i*DIM+j]) * longint'(hvec[i]);
                else        acc += longint'(w1[i*DIM+j]) * longint'(xvec[i]);
            end
            return round_sat(acc);
        endfunction

        // Update the model state for one accepted input transfer.
        function void note_input(logic [1:0] cmd, logic layer, logic [4:0] row,
                                 logic [4:0] col, logic signed [15:0] value);
            logic signed [15:0] h;
            t_out_elem          e;
            case (cmd)
                CMD_WEIGHT: begin
                    if (layer) w2[row*DIM+col] = value;
                    else       w1[row*DIM+col] = value;
                end
                CMD_BIAS: begin
                    if (layer) b2[col] = value;
                    else       b1[col] = value;
                end
                CMD_ELEM: begin
                    xvec[row] = value;
                    if (row == DIM - 1) begin
                        for (int j = 0; j < DIM; j++) begin
                            h = dot_column(1'b0, j);
                            hvec[j] = (h < 0) ? 16'sd0 : h;
                        end
                        for (int j = 0; j < DIM; j++) begin
                            e.idx   = j[4:0];
                            e.value = dot_column(1'b1, j);
                            e.last  = (j == DIM - 1);
                            expected_outputs.insert(expected_outputs.size(), e);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            mismatches++;
            $display("ERROR @%0t: %s", $realtime, what);
        endtask

        task check_output(logic [4:0] idx, logic signed [15:0] value, logic last);
            t_out_elem e;
            if (expected_outputs.size() == 0) begin
                report($sformatf("unexpected output idx=%0d value=%0d", idx, value));
            end else begin
                e = expected_outputs.pop_front();
                if (idx !== e.idx)
                    report($sformatf("index got %0d want %0d", idx, e.idx));
                if (value !== e.value)
                    report($sformatf("value idx %0d got %0d want %0d", e.idx, value, e.value));
                if (last !== e.last)
                    report($sformatf("last idx %0d got %b want %b", e.idx, last, e.last));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic [1:0]  i_cmd = '0;
    logic        i_layer = 1'b0;
    logic [4:0]  i_row = '0;
    logic [4:0]  i_col = '0;
    logic [15:0] i_value = '0;
    logic        i_pop = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic [4:0]  o_out_index;
    logic [15:0] o_out_value;
    logic        o_last;

    mlp_scoreboard sb = new();
    bit            calm = 1'b0;
    int            pop_hold = 0;
    int            sent = 0;

    two_layer_relu_mlp uut (.*);

    always #2 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: random pop, plus a long hold-off counted here.
    initial begin
        forever begin
            @(negedge i_clk);
            if (pop_hold > 0) begin
                pop_hold--;
                i_pop = 1'b0;
            end else begin
                i_pop = calm || ($urandom_range(99) >= 28);
            end
            @(posedge i_clk);
            if (i_rst_n && i_pop && !o_empty)
                sb.check_output(o_out_index, $signed(o_out_value), o_last);
        end
    end

    task send(logic [1:0] cmd, logic layer, logic [4:0] row, logic [4:0] col,
              logic [15:0] value);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 28) begin
            i_push = 1'b0;
            @(negedge i_clk);
        end
        i_push  = 1'b1;
        i_cmd   = cmd;
        i_layer = layer;
        i_row   = row;
        i_col   = col;
        i_value = value;
        do @(posedge i_clk); while (o_full);
        sb.note_input(cmd, layer, row, col, $signed(value));
        sent++;
    endtask

    function logic [15:0] rand_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return 16'($urandom_range(1023)) - 16'd512;
        if (pick < 85) return 16'($urandom);
        return pick[0] ? 16'h7fff : 16'h8000;
    endfunction

    task send_vector(bit shuffled);
        int order [DIM];
        int k;
        int tmp;
        for (int i = 0; i < DIM; i++) order[i] = i;
        if (shuffled)
            for (int i = 0; i < DIM - 1; i++) begin
                k = $urandom_range(DIM - 2, i);
                tmp = order[i];
                order[i] = order[k];
                order[k] = tmp;
            end
        for (int i = 0; i < DIM; i++)
            send(CMD_ELEM, 1'($urandom), order[i][4:0], 5'($urandom), rand_value());
    endtask

    task wait_drained();
        int guard;
        guard = 0;
        // stop offering before waiting so the last item is not taken again
        @(negedge i_clk);
        i_push = 1'b0;
        while (sb.expected_outputs.size() != 0) begin
            @(posedge i_clk);
            guard++;
            if (guard > 200000) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    endtask

    initial begin
        int pick;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill every weight, bias and input store before the first computation.
        for (int l = 0; l < 2; l++) begin
            for (int i = 0; i < DIM; i++)
                for (int j = 0; j < DIM; j++)
                    send(CMD_WEIGHT, l[0], i[4:0], j[4:0], 16'($urandom_range(255)) - 16'd128);
            for (int j = 0; j < DIM; j++)
                send(CMD_BIAS, l[0], 5'($urandom), j[4:0], rand_value());
        end
        send_vector(1'b0);

        // Directed: extremes, unused command, ignored fields, partial vector.
        send(CMD_UNUSED, 1'b1, 5'd31, 5'd31, 16'hffff);
        send(CMD_UNUSED, 1'b0, 5'd0, 5'd0, 16'h0000);
        send(CMD_BIAS, 1'b0, 5'd31, 5'd0, 16'h7fff);
        send(CMD_BIAS, 1'b1, 5'd17, 5'd31, 16'h8000);
        send(CMD_BIAS, 1'b1, 5'd0, 5'd1, 16'h7fff);
        send(CMD_WEIGHT, 1'b0, 5'd0, 5'd0, 16'h7fff);
        send(CMD_WEIGHT, 1'b0, 5'd31, 5'd31, 16'h8000);
        send(CMD_WEIGHT, 1'b1, 5'd0, 5'd31, 16'h8000);
        send(CMD_WEIGHT, 1'b1, 5'd31, 5'd0, 16'h7fff);
        send(CMD_ELEM, 1'b1, 5'd0, 5'd31, 16'h7fff);
        send(CMD_ELEM, 1'b0, 5'd5, 5'd7, 16'h8000);
        send(CMD_ELEM, 1'b1, 5'd31, 5'd31, 16'h7fff);
        send(CMD_ELEM, 1'b0, 5'd31, 5'd0, 16'h8000);
        send(CMD_ELEM, 1'b0, 5'd31, 5'd0, 16'h0000);
        send(CMD_ELEM, 1'b0, 5'd31, 5'd0, 16'hffff);

        // Hold the result side so both queues fill and input stalls.
        wait_drained();
        pop_hold = 3 * RUN_CYCLES;
        sent = 0;
        send(CMD_ELEM, 1'b0, 5'd31, 5'd0, rand_value());
        send(CMD_ELEM, 1'b1, 5'd31, 5'd3, rand_value());
        for (int i = 0; i < 6; i++)
            send(CMD_WEIGHT, 1'b1, 5'($urandom), 5'($urandom), rand_value());
        send(CMD_ELEM, 1'b0, 5'd31, 5'd0, rand_value());

        // Pause the sender until every output is out.
        wait_drained();
        repeat (RUN_CYCLES) @(negedge i_clk);

        while (sent < 210) begin
            calm = (sent >= 60 && sent < 110);
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_vector(pick[0]);
            end else if (pick < 75) begin
                send(CMD_WEIGHT, 1'($urandom), 5'($urandom), 5'($urandom), rand_value());
            end else if (pick < 85) begin
                send(CMD_BIAS, 1'($urandom), 5'($urandom), 5'($urandom), rand_value());
            end else if (pick < 93) begin
                send(CMD_ELEM, 1'($urandom), 5'($urandom), 5'($urandom), rand_value());
            end else begin
                send(CMD_UNUSED, 1'($urandom), 5'($urandom), 5'($urandom), 16'($urandom));
            end
        end
        calm = 1'b0;
        @(negedge i_clk);
        i_push = 1'b0;

        wait_drained();
        repeat (RUN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_outputs.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
